### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the delay mix RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CDM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/cdm_pkg.sv
// ----------------------------------------------------------------------------
// cdm_pkg
// Widths, register map, reset values and shared types of the delay mix.
// ----------------------------------------------------------------------------
package cdm_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;

    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CMP_W       = (CFG_W > LEN_W) ? CFG_W : LEN_W;

    localparam int SMP_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int FRAC_W      = 14;
    localparam int PROD_W      = GAIN_W + 1 + SMP_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int QUO_W       = ACC_W - FRAC_W;

    localparam logic [CFG_W-1:0]  RST_DELAY  = CFG_W'(11025);
    localparam logic [CFG_W-1:0]  RST_LENGTH = CFG_W'(44100);
    localparam logic [GAIN_W-1:0] RST_DRY    = GAIN_W'(13107);
    localparam logic [GAIN_W-1:0] RST_WET    = GAIN_W'(8192);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY  = 2'd0,
        REG_LENGTH = 2'd1,
        REG_DRY    = 2'd2,
        REG_WET    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic                     accept;
        logic                     hit;
        logic signed [SMP_W-1:0]  x;
    } t_issue;

endpackage

### rtl/cdm_in_if.sv
// ----------------------------------------------------------------------------
// cdm_in_if
// Input sample channel: valid/ready handshake with one sample per item.
// ----------------------------------------------------------------------------
interface cdm_in_if import cdm_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);

endinterface

### rtl/cdm_out_if.sv
// ----------------------------------------------------------------------------
// cdm_out_if
// Output sample channel: valid/ready handshake with one sample per item.
// ----------------------------------------------------------------------------
interface cdm_out_if import cdm_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);

endinterface

### rtl/cdm_ram.sv
// ----------------------------------------------------------------------------
// cdm_ram
// Generic simple dual-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module cdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cdm_addr.sv
// ----------------------------------------------------------------------------
// cdm_addr
// Write/read head generation, length and delay clamping, fill mark.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdm_addr import cdm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [CFG_W-1:0] i_delay,
    input  logic [CFG_W-1:0] i_length,
    output t_mem_req         o_mem,
    output logic             o_hit
);

    logic [ADDR_W-1:0] r_wp;
    logic [ADDR_W-1:0] n_wp;
    logic [LEN_W-1:0]  r_fill;
    logic [LEN_W-1:0]  n_fill;

    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  dly_ext;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  dly;
    logic [LEN_W-1:0]  wp;
    logic [LEN_W-1:0]  wp_inc;
    logic [LEN_W-1:0]  rp_raw;
    logic [LEN_W-1:0]  rp;

    always_comb begin
        len_ext = CMP_W'(i_length);
        dly_ext = CMP_W'(i_delay);

        if (len_ext == '0) begin
            len = LEN_W'(1);
        end else if (len_ext > CMP_W'(STORE_DEPTH)) begin
            len = LEN_W'(STORE_DEPTH);
        end else begin
            len = LEN_W'(len_ext);
        end

        if (dly_ext > CMP_W'(len)) begin
            dly = len;
        end else begin
            dly = LEN_W'(dly_ext);
        end

        wp = ({1'b0, r_wp} >= len) ? '0 : {1'b0, r_wp};

        if (wp >= dly) begin
            rp_raw = wp - dly;
        end else begin
            rp_raw = wp + len - dly;
        end
        rp = (rp_raw >= len) ? '0 : rp_raw;

        wp_inc = wp + LEN_W'(1);
    end

    always_comb begin
        n_wp   = r_wp;
        n_fill = r_fill;
        if (i_accept) begin
            n_wp = (wp_inc >= len) ? '0 : wp_inc[ADDR_W-1:0];
            if (wp >= r_fill) begin
                n_fill = wp_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    // Entries below the fill mark have been written since reset.
    assign o_hit       = (rp < r_fill);
    assign o_mem.we    = i_accept;
    assign o_mem.waddr = wp[ADDR_W-1:0];
    assign o_mem.re    = i_accept;
    assign o_mem.raddr = rp[ADDR_W-1:0];

    `CDM_ASSERT(a_fill_bound, r_fill <= LEN_W'(STORE_DEPTH), "fill mark beyond store depth")
    `CDM_ASSERT(a_fill_covers, i_accept |=> ({1'b0, $past(o_mem.waddr)} < r_fill), "written entry not covered by fill mark")

endmodule

### rtl/cdm_mix.sv
// ----------------------------------------------------------------------------
// cdm_mix
// Gain multiply, round toward zero, saturate; elastic output pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdm_mix import cdm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_issue            i_issue,
    input  logic [SMP_W-1:0]  i_rd_data,
    input  logic [GAIN_W-1:0] i_dry,
    input  logic [GAIN_W-1:0] i_wet,
    output logic              o_take,
    cdm_out_if.source         o_out
);

    // stage 1: read data from RAM
    logic                      r_v1;
    logic                      r_hit1;
    logic signed [SMP_W-1:0]   r_x1;
    // stage 2: products
    logic                      r_v2;
    logic signed [PROD_W-1:0]  r_p_dry;
    logic signed [PROD_W-1:0]  r_p_wet;
    // output register
    logic                      r_vout;
    logic signed [SMP_W-1:0]   r_out;

    logic                      en1;
    logic                      en2;
    logic                      en_out;
    logic signed [SMP_W-1:0]   d1;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_b;
    logic signed [QUO_W-1:0]   quo;
    logic signed [SMP_W-1:0]   sat;
    logic [QUO_W-SMP_W:0]      top_bits;

    assign en_out = !r_vout || o_out.ready;
    assign en2    = !r_v2 || en_out;
    assign en1    = !r_v1 || en2;
    assign o_take = en1;

    assign d1 = r_hit1 ? $signed(i_rd_data) : '0;

    always_comb begin
        acc   = {r_p_dry[PROD_W-1], r_p_dry} + {r_p_wet[PROD_W-1], r_p_wet};
        // bias negative sums so the shift truncates toward zero
        acc_b = acc[ACC_W-1] ? acc + ACC_W'((1 << FRAC_W) - 1) : acc;
        quo   = acc_b[ACC_W-1:FRAC_W];
        top_bits = quo[QUO_W-1:SMP_W-1];
        if ((top_bits == '0) || (top_bits == '1)) begin
            sat = quo[SMP_W-1:0];
        end else if (quo[QUO_W-1]) begin
            sat = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(SMP_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_issue.accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en_out) begin
                r_vout <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_issue.accept) begin
            r_x1   <= i_issue.x;
            r_hit1 <= i_issue.hit;
        end
        if (en2) begin
            r_p_dry <= $signed({1'b0, i_dry}) * r_x1;
            r_p_wet <= $signed({1'b0, i_wet}) * d1;
        end
        if (en_out) begin
            r_out <= sat;
        end
    end

    assign o_out.valid      = r_vout;
    assign o_out.sample_out = r_out;

    `CDM_ASSERT(a_rd_hold, (r_v1 && !en2) |=> (r_v1 && $stable(i_rd_data)), "read data lost while stage 1 stalled")
    `CDM_ASSERT(a_out_src, $rose(r_vout) |-> $past(r_v2), "output valid without a product stage item")

endmodule

### rtl/circular_delay_mix_unit.sv
// ----------------------------------------------------------------------------
// circular_delay_mix_unit
// Feedforward delay line with dry/wet mix over a circular sample store.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          sample_in  (s16)
//  o_out     out  valid/ready          sample_out (s16)
//  i_cfg_*   in   write enable only    index 2b, data 17b
//
//  One item per cycle unless o_out stalls; an accepted item passes r_v1 and r_v2, then o_out.valid rises from r_vout.
//  Each item does one store read and one store write in its accept cycle.
//  Synchronous reset; i_in.ready rises in the cycle after reset release.
//  No clearing pass: a fill mark makes unwritten entries read as zero.
//  A stall on o_out backs up through the pipeline; bubbles still fill.
// ----------------------------------------------------------------------------
module circular_delay_mix_unit import cdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cdm_in_if.sink               i_in,
    cdm_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]  r_delay;
    logic [CFG_W-1:0]  r_length;
    logic [GAIN_W-1:0] r_dry;
    logic [GAIN_W-1:0] r_wet;
    logic              r_up;

    logic              take;
    logic              accept;
    logic              hit;
    t_mem_req          mem;
    t_issue            issue;
    logic [SMP_W-1:0]  rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= RST_DELAY;
            r_length <= RST_LENGTH;
            r_dry    <= RST_DRY;
            r_wet    <= RST_WET;
            r_up     <= 1'b0;
        end else begin
            r_up <= 1'b1;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_DELAY:  r_delay  <= i_cfg_data;
                    REG_LENGTH: r_length <= i_cfg_data;
                    REG_DRY:    r_dry    <= i_cfg_data[GAIN_W-1:0];
                    REG_WET:    r_wet    <= i_cfg_data[GAIN_W-1:0];
                endcase
            end
        end
    end

    assign i_in.ready = r_up && take;
    assign accept     = i_in.valid && i_in.ready;

    cdm_addr u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_delay  (r_delay),
        .i_length (r_length),
        .o_mem    (mem),
        .o_hit    (hit)
    );

    cdm_ram #(
        .WIDTH (SMP_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (i_in.sample_in),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rd_data)
    );

    assign issue.accept = accept;
    assign issue.hit    = hit;
    assign issue.x      = i_in.sample_in;

    cdm_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_rd_data (rd_data),
        .i_dry     (r_dry),
        .i_wet     (r_wet),
        .o_take    (take),
        .o_out     (o_out)
    );

endmodule
